// ===== hdl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

   localparam int unsigned INDEX_BITS  = 4;
   localparam int unsigned FIELD_BITS  = 16;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  granted;
      logic [INDEX_BITS-1:0] block_index;
      logic [FIELD_BITS-1:0] remaining_size;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/bfa_size_ram.sv =====
`default_nettype none

module bfa_size_ram #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bfa_scan_ctrl.sv =====
`default_nettype none

module bfa_scan_ctrl
   import bfa_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 16,
   parameter int unsigned SIZE_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [FIELD_BITS-1:0] req_size,
   input  wire logic                  out_free,
   output logic                       res_valid,
   output result_type                 res
);

   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_val_ff, best_val_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [SIZE_BITS-1:0] rd_data;
   logic [SIZE_BITS-1:0] req_size_w;
   logic [SIZE_BITS-1:0] diff;

   assign req_size_w = SIZE_BITS'(req_size);
   assign diff       = best_val_ff - size_ff;

   bfa_size_ram #(
      .DEPTH  (MAX_BLOCKS),
      .WIDTH  (SIZE_BITS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      size_ff     <= size_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rd_idx_ff   <= rd_idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      size_in     = size_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_data     = req_size_w;
      rd_en       = 1'b0;
      rd_addr     = issue_ff[IDX_W-1:0];
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      res         = '0;

      // fold in the entry read last cycle
      if (rd_valid_ff && (rd_data >= size_ff) && (!found_ff || (rd_data < best_val_ff))) begin
         found_in    = 1'b1;
         best_idx_in = rd_idx_ff;
         best_val_in = rd_data;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_mode) begin
                  if (count_ff < CNT_W'(MAX_BLOCKS)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  size_in  = req_size_w;
                  issue_in = '0;
                  found_in = 1'b0;
                  state_in = (count_ff == '0) ? S_DONE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               if (found_ff) begin
                  res.granted        = 1'b1;
                  res.block_index    = INDEX_BITS'(best_idx_ff);
                  res.remaining_size = FIELD_BITS'(diff);
                  wr_en              = 1'b1;
                  wr_addr            = best_idx_ff;
                  wr_data            = diff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("loaded count beyond capacity");

   a_full_load_dropped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !req_mode && count_ff == CNT_W'(MAX_BLOCKS))
      |=> $stable(count_ff))
      else $error("load past capacity changed count");

   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == S_SCAN))
      else $error("read data outside scan");

   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && found_ff) |-> (best_val_ff >= size_ff))
      else $error("chosen block smaller than request");

   a_count_fixed_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> $stable(count_ff))
      else $error("count changed during scan");
`endif

endmodule

`default_nettype wire

// ===== hdl/best_fit_block_allocator.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_mode, req_size
// rsp       out        rsp_valid/rsp_ready  rsp_granted, rsp_block_index, rsp_remaining_size
//
// A load writes the size to the next free entry; a load into a full table is dropped.
// A request reads one entry per cycle, then drains the last read and, if a block fits,
// writes back its remaining size: its result is registered when the output register is
// free, and the next transfer is taken once the controller is back in idle.
// Synchronous reset empties the table; a waiting result lets loads continue, while a
// further request stalls before write-back until the output register is free.
`default_nettype none

module best_fit_block_allocator
   import bfa_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 16,
   parameter int unsigned SIZE_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [FIELD_BITS-1:0] req_size,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_granted,
   output logic [INDEX_BITS-1:0]      rsp_block_index,
   output logic [FIELD_BITS-1:0]      rsp_remaining_size
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff;
   logic       out_free;
   logic       res_valid;
   result_type res;

   assign out_free = !rsp_valid_ff || rsp_ready;

   bfa_scan_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_size  (req_size),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_res_ff.granted;
   assign rsp_block_index    = rsp_res_ff.block_index;
   assign rsp_remaining_size = rsp_res_ff.remaining_size;

endmodule

`default_nettype wire
